// File: hw/rtl/siu_pkg.sv
// siu_pkg: shared constants for the segment intersection unit
// no dependencies; imported by the interfaces and every rtl module
`default_nettype none

package siu_pkg;

  // default coordinate width, two's complement with 4 fractional bits
  localparam int COORD_WIDTH_DEF = 16;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

endpackage

`default_nettype wire

// File: hw/rtl/siu_if.sv
// siu_in_if / siu_out_if: valid-ready channels for segment pairs and results
// depends on siu_pkg for the default coordinate width
`default_nettype none

interface siu_in_if import siu_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a_start_x;
  logic signed [W-1:0] a_start_y;
  logic signed [W-1:0] a_end_x;
  logic signed [W-1:0] a_end_y;
  logic signed [W-1:0] b_start_x;
  logic signed [W-1:0] b_start_y;
  logic signed [W-1:0] b_end_x;
  logic signed [W-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface siu_out_if import siu_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;

  modport source (output valid, hit, point_x, point_y, input ready);
  modport sink (input valid, hit, point_x, point_y, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/segment_intersection_unit_core.sv
// segment_intersection_unit_core: parametric line segment intersection
// throughput: one segment pair per cycle while the result channel is ready; the divider is a
//   fully pipelined restoring array, one quotient bit per stage, so it adds no stall of its own
// reset: synchronous active-low rst_n clears all stage valids and the queue
// depends on siu_pkg, siu_if, siu_front, siu_queue, siu_back
`default_nettype none

module segment_intersection_unit_core import siu_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  siu_in_if.sink    in_chan,
  siu_out_if.source out_chan
);

  // packet: hit, denominator, two numerator products, start point
  localparam int PKT_W = 1 + (2 * COORD_WIDTH + 3) + 2 * (3 * COORD_WIDTH + 4)
                         + 2 * COORD_WIDTH;

  logic             f_valid, f_ready;
  logic [PKT_W-1:0] f_data;
  logic             b_valid, b_ready;
  logic [PKT_W-1:0] b_data;

  // front: differences, cross products, in-range test and point numerators
  siu_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .PKT_W       (PKT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .pkt_valid (f_valid),
    .pkt_ready (f_ready),
    .pkt_data  (f_data)
  );

  // decoupling queue so the front and back stall independently
  siu_queue #(
    .DATA_W (PKT_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  // back: truncating division per axis and the final point
  siu_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .PKT_W       (PKT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (b_valid),
    .pkt_ready (b_ready),
    .pkt_data  (b_data),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// File: hw/rtl/siu_front.sv
// siu_front: four-stage pipeline forming direction vectors, cross products,
// the hit decision and the two numerator products; depends on siu_pkg
`default_nettype none

module siu_front import siu_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int PKT_W       = 1 + (2 * COORD_WIDTH + 3) + 2 * (3 * COORD_WIDTH + 4)
                              + 2 * COORD_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  siu_in_if.sink                in_chan,
  output logic                  pkt_valid,
  input  wire logic             pkt_ready,
  output logic [PKT_W-1:0]      pkt_data
);

  localparam int W = COORD_WIDTH;
  localparam int D = W + 1;
  localparam int P = 2 * W + 2;
  localparam int N = 2 * W + 3;
  localparam int M = 3 * W + 4;

  logic [3:0] v_r;
  logic       en;

  // stage 1: differences
  logic signed [D-1:0] s1x_r, s1y_r, s2x_r, s2y_r, dx_r, dy_r;
  logic signed [W-1:0] ax_r [1:4];
  logic signed [W-1:0] ay_r [1:4];
  // stage 2: products
  logic signed [P-1:0] p_s1x_s2y_r, p_s2x_s1y_r, p_s1x_dy_r, p_s1y_dx_r;
  logic signed [P-1:0] p_s2x_dy_r, p_s2y_dx_r;
  logic signed [D-1:0] s1x2_r, s1y2_r;
  // stage 3: denominator and numerators
  logic signed [N-1:0] den_r, ns_r, nt_r;
  logic signed [D-1:0] s1x3_r, s1y3_r;
  // stage 4: decision and point products
  logic                hit_r;
  logic signed [N-1:0] den4_r;
  logic signed [M-1:0] nx_r, ny_r;

  function automatic logic in_unit(input logic signed [N-1:0] n,
                                   input logic signed [N-1:0] d);
    if (d < 0) begin
      return (n >= d) && (n <= 0);
    end
    return (n >= 0) && (n <= d);
  endfunction

  assign en            = !v_r[3] || pkt_ready;
  assign in_chan.ready = en;
  assign pkt_valid     = v_r[3];
  assign pkt_data      = {hit_r, den4_r, nx_r, ny_r, ax_r[4], ay_r[4]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1x_r    <= D'(in_chan.a_end_x) - D'(in_chan.a_start_x);
      s1y_r    <= D'(in_chan.a_end_y) - D'(in_chan.a_start_y);
      s2x_r    <= D'(in_chan.b_end_x) - D'(in_chan.b_start_x);
      s2y_r    <= D'(in_chan.b_end_y) - D'(in_chan.b_start_y);
      dx_r     <= D'(in_chan.a_start_x) - D'(in_chan.b_start_x);
      dy_r     <= D'(in_chan.a_start_y) - D'(in_chan.b_start_y);
      ax_r[1]  <= in_chan.a_start_x;
      ay_r[1]  <= in_chan.a_start_y;

      p_s1x_s2y_r <= P'(s1x_r) * P'(s2y_r);
      p_s2x_s1y_r <= P'(s2x_r) * P'(s1y_r);
      p_s1x_dy_r  <= P'(s1x_r) * P'(dy_r);
      p_s1y_dx_r  <= P'(s1y_r) * P'(dx_r);
      p_s2x_dy_r  <= P'(s2x_r) * P'(dy_r);
      p_s2y_dx_r  <= P'(s2y_r) * P'(dx_r);
      s1x2_r      <= s1x_r;
      s1y2_r      <= s1y_r;
      ax_r[2]     <= ax_r[1];
      ay_r[2]     <= ay_r[1];

      den_r   <= N'(p_s1x_s2y_r) - N'(p_s2x_s1y_r);
      ns_r    <= N'(p_s1x_dy_r) - N'(p_s1y_dx_r);
      nt_r    <= N'(p_s2x_dy_r) - N'(p_s2y_dx_r);
      s1x3_r  <= s1x2_r;
      s1y3_r  <= s1y2_r;
      ax_r[3] <= ax_r[2];
      ay_r[3] <= ay_r[2];

      // zero denominator: parallel, collinear or degenerate
      hit_r   <= (den_r != '0) && in_unit(ns_r, den_r) && in_unit(nt_r, den_r);
      den4_r  <= den_r;
      nx_r    <= M'(nt_r) * M'(s1x3_r);
      ny_r    <= M'(nt_r) * M'(s1y3_r);
      ax_r[4] <= ax_r[3];
      ay_r[4] <= ay_r[3];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/siu_queue.sv
// siu_queue: small valid-ready fifo between front and back
// depends on siu_pkg for the default depth
`default_nettype none

module siu_queue import siu_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output logic [DATA_W-1:0]      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;
  logic              push, pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/siu_back.sv
// siu_back: pipelined restoring divider for both axes and final point add
// depends on siu_pkg; fed by siu_queue, drives the result channel
`default_nettype none

module siu_back import siu_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int PKT_W       = 1 + (2 * COORD_WIDTH + 3) + 2 * (3 * COORD_WIDTH + 4)
                              + 2 * COORD_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pkt_valid,
  output logic                  pkt_ready,
  input  wire logic [PKT_W-1:0] pkt_data,
  siu_out_if.source             out_chan
);

  localparam int W  = COORD_WIDTH;
  localparam int N  = 2 * W + 3;
  localparam int M  = 3 * W + 4;
  localparam int Q  = W + 1;     // quotient bits, |quotient| <= |s1| <= 2^W
  localparam int LS = Q + 1;     // output stage index

  logic                hit_in;
  logic signed [N-1:0] den_in;
  logic signed [M-1:0] nx_in, ny_in;
  logic signed [W-1:0] ax_in, ay_in;

  assign {hit_in, den_in, nx_in, ny_in, ax_in, ay_in} = pkt_data;

  logic [LS:0]         v_r;
  logic                en;
  logic                hit_r  [0:Q];
  logic                sgx_r  [0:Q];
  logic                sgy_r  [0:Q];
  logic [N-1:0]        dmag_r [0:Q];
  logic [M-1:0]        remx_r [0:Q];
  logic [M-1:0]        remy_r [0:Q];
  logic [Q-1:0]        qx_r   [0:Q];
  logic [Q-1:0]        qy_r   [0:Q];
  logic signed [W-1:0] ax_r   [0:Q];
  logic signed [W-1:0] ay_r   [0:Q];
  logic                hit_o_r;
  logic signed [W-1:0] px_r, py_r;

  assign en               = !v_r[LS] || out_chan.ready;
  assign pkt_ready        = en;
  assign out_chan.valid   = v_r[LS];
  assign out_chan.hit     = hit_o_r;
  assign out_chan.point_x = px_r;
  assign out_chan.point_y = py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LS-1:0], pkt_valid};
    end
  end

  // stage 0: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r[0]  <= hit_in;
      sgx_r[0]  <= nx_in[M-1] ^ den_in[N-1];
      sgy_r[0]  <= ny_in[M-1] ^ den_in[N-1];
      dmag_r[0] <= den_in[N-1] ? -den_in : den_in;
      remx_r[0] <= nx_in[M-1] ? -nx_in : nx_in;
      remy_r[0] <= ny_in[M-1] ? -ny_in : ny_in;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      ax_r[0]   <= ax_in;
      ay_r[0]   <= ay_in;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k <= Q; k++) begin : g_div
    localparam int B = Q - k;
    logic [M:0]   dsh;
    logic [M:0]   tx, ty;
    logic [Q-1:0] qx_nxt, qy_nxt;

    always_comb begin
      dsh       = (M + 1)'(dmag_r[k-1]) << B;
      tx        = {1'b0, remx_r[k-1]} - dsh;
      ty        = {1'b0, remy_r[k-1]} - dsh;
      qx_nxt    = qx_r[k-1];
      qy_nxt    = qy_r[k-1];
      qx_nxt[B] = !tx[M];
      qy_nxt[B] = !ty[M];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hit_r[k]  <= hit_r[k-1];
        sgx_r[k]  <= sgx_r[k-1];
        sgy_r[k]  <= sgy_r[k-1];
        dmag_r[k] <= dmag_r[k-1];
        remx_r[k] <= tx[M] ? remx_r[k-1] : tx[M-1:0];
        remy_r[k] <= ty[M] ? remy_r[k-1] : ty[M-1:0];
        qx_r[k]   <= qx_nxt;
        qy_r[k]   <= qy_nxt;
        ax_r[k]   <= ax_r[k-1];
        ay_r[k]   <= ay_r[k-1];
      end
    end
  end

  // output stage: sign the quotient, add the start point, clear on miss
  logic signed [Q:0] qsx, qsy;
  logic [Q:0]        sumx, sumy;

  always_comb begin
    qsx  = sgx_r[Q] ? -$signed({1'b0, qx_r[Q]}) : $signed({1'b0, qx_r[Q]});
    qsy  = sgy_r[Q] ? -$signed({1'b0, qy_r[Q]}) : $signed({1'b0, qy_r[Q]});
    sumx = (Q + 1)'(ax_r[Q]) + qsx;
    sumy = (Q + 1)'(ay_r[Q]) + qsy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_o_r <= hit_r[Q];
      px_r    <= hit_r[Q] ? sumx[W-1:0] : '0;
      py_r    <= hit_r[Q] ? sumy[W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// File: verif/segment_intersection_unit_core_tb.sv
// testbench for segment_intersection_unit_core: random and directed segment pairs
// depends on siu_pkg, siu_if and the rtl of the core; self-checking, no files read
`default_nettype none

module testbench;
  import siu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = COORD_WIDTH_DEF;
  localparam int LATENCY = W + 8;
  localparam int STALL_LIMIT = 2000;

  typedef logic signed [W-1:0] coord_t;

  typedef struct packed {
    coord_t asx, asy, aex, aey, bsx, bsy, bex, bey;
  } seg_pair_t;

  typedef struct packed {
    logic   hit;
    coord_t px, py;
  } crossing_t;

  // exact crossing computation, wide enough for every intermediate product
  function automatic crossing_t crossing_of(seg_pair_t p);
    logic signed [127:0] ax, ay, s1x, s1y, s2x, s2y, dx, dy, den, ns, nt, qx, qy;
    logic signed [127:0] mag_n, mag_d;
    crossing_t r;
    ax  = p.asx;
    ay  = p.asy;
    s1x = 128'(signed'(p.aex)) - ax;
    s1y = 128'(signed'(p.aey)) - ay;
    s2x = 128'(signed'(p.bex)) - 128'(signed'(p.bsx));
    s2y = 128'(signed'(p.bey)) - 128'(signed'(p.bsy));
    dx  = ax - 128'(signed'(p.bsx));
    dy  = ay - 128'(signed'(p.bsy));
    den = s1x * s2y - s2x * s1y;
    ns  = s1x * dy - s1y * dx;
    nt  = s2x * dy - s2y * dx;
    r = '0;
    if (den != 0 && in_unit(ns, den) && in_unit(nt, den)) begin
      // truncating division done on magnitudes to keep it explicit
      mag_d = (den < 0) ? -den : den;
      mag_n = nt * s1x;
      qx = ((mag_n < 0) ? -mag_n : mag_n) / mag_d;
      if ((mag_n < 0) != (den < 0)) qx = -qx;
      mag_n = nt * s1y;
      qy = ((mag_n < 0) ? -mag_n : mag_n) / mag_d;
      if ((mag_n < 0) != (den < 0)) qy = -qy;
      r.hit = 1'b1;
      r.px  = coord_t'(ax + qx);
      r.py  = coord_t'(ay + qy);
    end
    return r;
  endfunction

  // 0 <= n/d <= 1 for nonzero d
  function automatic bit in_unit(logic signed [127:0] n, logic signed [127:0] d);
    if (d < 0) return (d <= n) && (n <= 0);
    return (n >= 0) && (n <= d);
  endfunction

  class crossing_board;
    crossing_t pending[$];
    int        errors;

    function void note_pair(seg_pair_t p);
      pending.push_back(crossing_of(p));
    endfunction

    function void check_result(crossing_t got);
      crossing_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0b x=%0d y=%0d",
                 $time, got.hit, got.px, got.py);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.px !== want.px) begin
        $display("%0t: point_x expected %0d actual %0d", $time, want.px, got.px);
        errors++;
      end
      if (got.py !== want.py) begin
        $display("%0t: point_y expected %0d actual %0d", $time, want.py, got.py);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  siu_in_if  #(.W(W)) in_chan ();
  siu_out_if #(.W(W)) out_chan ();

  segment_intersection_unit_core #(.COORD_WIDTH(W)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  crossing_board board = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  int  quiet_cycles;

  initial begin
    in_chan.valid = 1'b0;
    {in_chan.a_start_x, in_chan.a_start_y, in_chan.a_end_x, in_chan.a_end_y,
     in_chan.b_start_x, in_chan.b_start_y, in_chan.b_end_x, in_chan.b_end_y} = '0;
    out_chan.ready = 1'b0;
  end

  // receiver: random back-pressure, results checked at the accepting edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready)
        board.check_result({out_chan.hit, out_chan.point_x, out_chan.point_y});
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_n && quiet_cycles >= STALL_LIMIT) begin
      $display("segment_intersection_unit_core regression: fail");
      $finish;
    end
  end

  // one beat into the block, with a random gap in front of it
  task automatic send_pair(seg_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.a_start_x <= p.asx;
    in_chan.a_start_y <= p.asy;
    in_chan.a_end_x   <= p.aex;
    in_chan.a_end_y   <= p.aey;
    in_chan.b_start_x <= p.bsx;
    in_chan.b_start_y <= p.bsy;
    in_chan.b_end_x   <= p.bex;
    in_chan.b_end_y   <= p.bey;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_pair(p);
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  // random pair; half of them crossing-shaped so the hit path gets real use
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int span, kind;
    kind = $urandom_range(9);
    span = (kind < 3) ? 0 : (kind < 6 ? 16000 : 200);
    p = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
         rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
    if (kind >= 3 && kind < 8) begin
      // B runs through the neighbourhood of A's midpoint
      p.bex = coord_t'(p.asx + p.aex - p.bsx + rand_coord(20) / 2);
      p.bey = coord_t'(p.asy + p.aey - p.bsy + rand_coord(20) / 2);
    end else if (kind == 8) begin
      // parallel to A, zero denominator
      p.bex = coord_t'(p.bsx + (p.aex - p.asx));
      p.bey = coord_t'(p.bsy + (p.aey - p.asy));
    end
    return p;
  endfunction

  localparam coord_t CMAX = coord_t'({1'b0, {(W-1){1'b1}}});
  localparam coord_t CMIN = coord_t'({1'b1, {(W-1){1'b0}}});

  initial begin
    seg_pair_t directed[$];
    int phase, n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain cross through the origin
    directed.push_back({-16'sd160, 16'sd0, 16'sd160, 16'sd0, 16'sd0, -16'sd160, 16'sd0, 16'sd160});
    // touching at an endpoint, both bounds included
    directed.push_back({16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd64, 16'sd0, 16'sd64, 16'sd64});
    directed.push_back({16'sd0, 16'sd0, 16'sd64, 16'sd64, 16'sd0, 16'sd0, 16'sd64, -16'sd64});
    // parallel, collinear overlapping, degenerate segment
    directed.push_back({16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd16, 16'sd64, 16'sd16});
    directed.push_back({16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd32, 16'sd0, 16'sd96, 16'sd0});
    directed.push_back({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd9, 16'sd9});
    // lines cross but outside one segment
    directed.push_back({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd32, -16'sd16, 16'sd32, 16'sd16});
    // full-scale extremes, non-integer crossing, truncation both signs
    directed.push_back({CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN});
    directed.push_back({CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX});
    directed.push_back({CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX});
    directed.push_back({CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN});
    directed.push_back({16'sd0, 16'sd0, 16'sd7, 16'sd3, 16'sd0, 16'sd3, 16'sd7, -16'sd1});
    directed.push_back({16'sd0, 16'sd0, -16'sd7, -16'sd3, 16'sd0, -16'sd3, -16'sd7, 16'sd1});
    directed.push_back({-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});
    foreach (directed[i]) send_pair(directed[i]);

    // three idling phases over the random part
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1 ? 56 : 0);
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1 ? 34 : 0);
      for (n = 0; n < 217; n++) send_pair(rand_pair());
    end
    in_chan.valid <= 1'b0;

    // drain, then keep waiting to catch stray beats
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("segment_intersection_unit_core regression: pass");
    else
      $display("segment_intersection_unit_core regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/siu_pkg.sv
hw/rtl/siu_if.sv
hw/rtl/siu_front.sv
hw/rtl/siu_queue.sv
hw/rtl/siu_back.sv
hw/rtl/segment_intersection_unit_core.sv
verif/segment_intersection_unit_core_tb.sv
